/* rtl/lspe_pkg.sv */
// Shared types and constants of the LED strip pixel encoder.
package lspe_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [1:0] REG_DUTY_HIGH  = 2'd1;
  localparam logic [1:0] REG_DUTY_LOW   = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DUTY_W     = 16;

  // Color pipeline depth and the width of its occupancy count
  localparam int unsigned FRONT_STAGES = 5;
  localparam int unsigned OCC_W        = $clog2(FRONT_STAGES + 1);

  // Bits per pixel on the wire
  localparam int unsigned PIXEL_BITS = 24;
  localparam int unsigned SLOT_W     = $clog2(PIXEL_BITS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PIXEL_BITS - 1);

  typedef struct packed {
    logic [PIXEL_BITS-1:0] grb;
    logic                  last;
  } pixel_t;

  typedef struct packed {
    logic [DUTY_W-1:0] high;
    logic [DUTY_W-1:0] low;
  } duty_cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SLOT,
    BK_GAP
  } back_state_e;

endpackage

/* rtl/lspe_front.sv */
// Color front end: HSV conversion by mode and brightness scaling in a fixed pipeline.
module lspe_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           mode_i,
  input  logic [7:0]                     c0_i,
  input  logic [7:0]                     c1_i,
  input  logic [7:0]                     c2_i,
  input  logic                           last_i,
  input  logic [7:0]                     brightness_i,
  output logic                           push_o,
  output lspe_pkg::pixel_t               pixel_o,
  output logic [lspe_pkg::OCC_W-1:0]     occ_o
);
  import lspe_pkg::*;

  localparam logic [7:0] HUE_SPAN = 8'd43;

  function automatic logic [7:0] scale_ch(input logic [7:0] x, input logic [7:0] b);
    logic [15:0] prod;
    prod = x * b;
    return (b == 8'd255) ? x : prod[15:8];
  endfunction

  logic [FRONT_STAGES-1:0] vld_q;

  // Stage 1: input capture with hue region and remainder
  logic       s1_mode_q, s1_last_q;
  logic [7:0] s1_c0_q, s1_c1_q, s1_c2_q, s1_rem_q;
  logic [2:0] s1_region_q;
  // Stage 2: first products
  logic       s2_mode_q, s2_last_q;
  logic [7:0] s2_c0_q, s2_c1_q, s2_c2_q, s2_p_q, s2_x1_q, s2_x2_q;
  logic [2:0] s2_region_q;
  // Stage 3: q and t
  logic       s3_mode_q, s3_last_q;
  logic [7:0] s3_c0_q, s3_c1_q, s3_c2_q, s3_p_q, s3_q_q, s3_t_q;
  logic [2:0] s3_region_q;
  // Stage 4: selected rgb
  logic       s4_last_q;
  logic [7:0] s4_r_q, s4_g_q, s4_b_q;
  // Stage 5: scaled and packed
  logic       s5_last_q;
  logic [PIXEL_BITS-1:0] s5_grb_q;

  logic [2:0]  region_d;
  logic [7:0]  base_d, off_d, rem_d;
  logic [15:0] p_prod, x1_prod, x2_prod, q_prod, t_prod;
  logic [7:0]  r_d, g_d, b_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FRONT_STAGES-2:0], in_valid_i};
    end
  end

  // Region is h/43, found by comparisons against the region bases
  always_comb begin
    if (c0_i >= 8'd215) begin
      region_d = 3'd5;
      base_d   = 8'd215;
    end else if (c0_i >= 8'd172) begin
      region_d = 3'd4;
      base_d   = 8'd172;
    end else if (c0_i >= 8'd129) begin
      region_d = 3'd3;
      base_d   = 8'd129;
    end else if (c0_i >= 8'd86) begin
      region_d = 3'd2;
      base_d   = 8'd86;
    end else if (c0_i >= HUE_SPAN) begin
      region_d = 3'd1;
      base_d   = HUE_SPAN;
    end else begin
      region_d = 3'd0;
      base_d   = 8'd0;
    end
    off_d = c0_i - base_d;
    rem_d = (off_d << 2) + (off_d << 1);
  end

  always_ff @(posedge clk_i) begin
    s1_mode_q   <= mode_i;
    s1_last_q   <= last_i;
    s1_c0_q     <= c0_i;
    s1_c1_q     <= c1_i;
    s1_c2_q     <= c2_i;
    s1_region_q <= region_d;
    s1_rem_q    <= rem_d;
  end

  assign p_prod  = s1_c2_q * (8'd255 - s1_c1_q);
  assign x1_prod = s1_c1_q * s1_rem_q;
  assign x2_prod = s1_c1_q * (8'd255 - s1_rem_q);

  always_ff @(posedge clk_i) begin
    s2_mode_q   <= s1_mode_q;
    s2_last_q   <= s1_last_q;
    s2_c0_q     <= s1_c0_q;
    s2_c1_q     <= s1_c1_q;
    s2_c2_q     <= s1_c2_q;
    s2_region_q <= s1_region_q;
    s2_p_q      <= p_prod[15:8];
    s2_x1_q     <= x1_prod[15:8];
    s2_x2_q     <= x2_prod[15:8];
  end

  assign q_prod = s2_c2_q * (8'd255 - s2_x1_q);
  assign t_prod = s2_c2_q * (8'd255 - s2_x2_q);

  always_ff @(posedge clk_i) begin
    s3_mode_q   <= s2_mode_q;
    s3_last_q   <= s2_last_q;
    s3_c0_q     <= s2_c0_q;
    s3_c1_q     <= s2_c1_q;
    s3_c2_q     <= s2_c2_q;
    s3_region_q <= s2_region_q;
    s3_p_q      <= s2_p_q;
    s3_q_q      <= q_prod[15:8];
    s3_t_q      <= t_prod[15:8];
  end

  // RGB passes through; zero saturation gives grey
  always_comb begin
    r_d = s3_c0_q;
    g_d = s3_c1_q;
    b_d = s3_c2_q;
    if (s3_mode_q) begin
      if (s3_c1_q == 8'd0) begin
        r_d = s3_c2_q;
        g_d = s3_c2_q;
        b_d = s3_c2_q;
      end else begin
        case (s3_region_q)
          3'd0: begin
            r_d = s3_c2_q; g_d = s3_t_q;  b_d = s3_p_q;
          end
          3'd1: begin
            r_d = s3_q_q;  g_d = s3_c2_q; b_d = s3_p_q;
          end
          3'd2: begin
            r_d = s3_p_q;  g_d = s3_c2_q; b_d = s3_t_q;
          end
          3'd3: begin
            r_d = s3_p_q;  g_d = s3_q_q;  b_d = s3_c2_q;
          end
          3'd4: begin
            r_d = s3_t_q;  g_d = s3_p_q;  b_d = s3_c2_q;
          end
          default: begin
            r_d = s3_c2_q; g_d = s3_p_q;  b_d = s3_q_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s4_last_q <= s3_last_q;
    s4_r_q    <= r_d;
    s4_g_q    <= g_d;
    s4_b_q    <= b_d;
  end

  always_ff @(posedge clk_i) begin
    s5_last_q <= s4_last_q;
    s5_grb_q  <= {scale_ch(s4_g_q, brightness_i), scale_ch(s4_r_q, brightness_i),
                  scale_ch(s4_b_q, brightness_i)};
  end

  assign push_o       = vld_q[FRONT_STAGES-1];
  assign pixel_o.grb  = s5_grb_q;
  assign pixel_o.last = s5_last_q;
  assign occ_o        = OCC_W'($countones(vld_q));

endmodule

/* rtl/lspe_queue.sv */
// Small first-word-fall-through queue of packed pixels.
module lspe_queue #(
  parameter int unsigned DEPTH = 4,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lspe_pkg::pixel_t din_i,
  input  logic             pop_i,
  output lspe_pkg::pixel_t dout_o,
  output logic             empty_o,
  output logic             full_o,
  output logic [CNT_W-1:0] cnt_o
);
  import lspe_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  pixel_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign dout_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign cnt_o   = cnt_q;

endmodule

/* rtl/lspe_back.sv */
// Bit-slot serializer: one duty value per cycle while it holds a pixel, then the frame gap after a frame-ending pixel.
module lspe_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lspe_pkg::duty_cfg_t             duty_cfg_i,
  input  logic                            q_empty_i,
  input  lspe_pkg::pixel_t                q_data_i,
  output logic                            q_pop_o,
  output logic                            valid_o,
  output logic [lspe_pkg::DUTY_W-1:0]     duty_o,
  output logic                            pixel_done_o,
  output logic                            frame_gap_o
);
  import lspe_pkg::*;

  back_state_e           state_q, state_d;
  logic [PIXEL_BITS-1:0] grb_q;
  logic [SLOT_W-1:0]     slot_q;
  logic                  last_q;
  logic                  slot_end;

  assign slot_end = (slot_q == LAST_SLOT);

  // Next state and queue pop
  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = BK_SLOT;
        end
      end
      BK_SLOT: begin
        if (slot_end) begin
          if (last_q) begin
            state_d = BK_GAP;
          end else if (!q_empty_i) begin
            q_pop_o = 1'b1;
            state_d = BK_SLOT;
          end else begin
            state_d = BK_IDLE;
          end
        end
      end
      BK_GAP: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = BK_SLOT;
        end else begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Result drive
  always_comb begin
    valid_o      = 1'b0;
    duty_o       = '0;
    pixel_done_o = 1'b0;
    frame_gap_o  = 1'b0;
    case (state_q)
      BK_SLOT: begin
        valid_o      = 1'b1;
        duty_o       = grb_q[PIXEL_BITS-1] ? duty_cfg_i.high : duty_cfg_i.low;
        pixel_done_o = slot_end;
      end
      BK_GAP: begin
        valid_o     = 1'b1;
        frame_gap_o = 1'b1;
      end
      default: begin
        valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) begin
        slot_q <= '0;
      end else if (state_q == BK_SLOT) begin
        slot_q <= slot_q + 1'b1;
      end
    end
  end

  // Load a popped pixel, otherwise shift out the sent bit
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      grb_q  <= q_data_i.grb;
      last_q <= q_data_i.last;
    end else if (state_q == BK_SLOT) begin
      grb_q <= grb_q << 1;
    end
  end

endmodule

/* rtl/led_strip_pixel_encoder_unit.sv */
// LED strip pixel encoder: five-stage color pipeline, queue and 24-slot serializer.
// Path: with the serializer idle, an accepted pixel passes the color pipeline, is written to
//   the queue, and is popped and loaded by the serializer, which then drives its first bit slot.
// Rate: set by the serializer, one slot per cycle while it holds a pixel and a gap result
//   after a frame-ending pixel. Busy rises once pipeline plus queue hold QUEUE_DEPTH items.
// Reset: brightness 255, both duties 0, pipeline and queue empty. The receiver cannot stall:
//   each result is shown for exactly one cycle with result_valid_o.
module led_strip_pixel_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Pixel command
  input  logic                            start,
  output logic                            busy,
  input  logic                            mode_i,
  input  logic [7:0]                      red_or_hue_i,
  input  logic [7:0]                      green_or_saturation_i,
  input  logic [7:0]                      blue_or_value_i,
  input  logic                            last_pixel_i,
  // Configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lspe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lspe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Results
  output logic                            result_valid_o,
  output logic [lspe_pkg::DUTY_W-1:0]     duty_o,
  output logic                            pixel_done_o,
  output logic                            frame_gap_o
);
  import lspe_pkg::*;

  localparam int unsigned Q_CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W   = $clog2(QUEUE_DEPTH + FRONT_STAGES + 1);

  logic [7:0] brightness_q;
  duty_cfg_t  duty_cfg_q;

  logic               accept;
  logic               q_push, q_pop, q_empty, q_full;
  pixel_t             front_pixel, q_data;
  logic [OCC_W-1:0]   front_occ;
  logic [Q_CNT_W-1:0] q_cnt;
  logic [SUM_W-1:0]   inflight;

  // Configuration is always taken; unknown indexes drop the write
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q    <= 8'd255;
      duty_cfg_q.high <= '0;
      duty_cfg_q.low  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_BRIGHTNESS: brightness_q    <= cfg_data_i[7:0];
        REG_DUTY_HIGH:  duty_cfg_q.high <= cfg_data_i[DUTY_W-1:0];
        REG_DUTY_LOW:   duty_cfg_q.low  <= cfg_data_i[DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Credit check: every item in the color pipeline has a queue slot reserved,
  // so the pipeline never has to stall.
  assign inflight = SUM_W'(front_occ) + SUM_W'(q_cnt);
  assign busy     = (inflight >= SUM_W'(QUEUE_DEPTH));
  assign accept   = start && !busy;

  lspe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (accept),
    .mode_i       (mode_i),
    .c0_i         (red_or_hue_i),
    .c1_i         (green_or_saturation_i),
    .c2_i         (blue_or_value_i),
    .last_i       (last_pixel_i),
    .brightness_i (brightness_q),
    .push_o       (q_push),
    .pixel_o      (front_pixel),
    .occ_o        (front_occ)
  );

  lspe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .din_i   (front_pixel),
    .pop_i   (q_pop),
    .dout_o  (q_data),
    .empty_o (q_empty),
    .full_o  (q_full),
    .cnt_o   (q_cnt)
  );

  lspe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .duty_cfg_i   (duty_cfg_q),
    .q_empty_i    (q_empty),
    .q_data_i     (q_data),
    .q_pop_o      (q_pop),
    .valid_o      (result_valid_o),
    .duty_o       (duty_o),
    .pixel_done_o (pixel_done_o),
    .frame_gap_o  (frame_gap_o)
  );

`ifndef NO_ASSERTIONS
  // A pipeline item must always find room in the queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (!q_full || q_pop))
    else $error("queue push while full");

  // Reserved credits never exceed the queue depth
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight <= SUM_W'(QUEUE_DEPTH))
    else $error("in-flight items exceed queue depth");

  // The gap result directly follows the final slot of a pixel
  a_gap_after_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_gap_o |-> ($past(result_valid_o) && $past(pixel_done_o)))
    else $error("frame gap without a finished pixel before it");

  // Pops happen only when the queue holds a pixel
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");
`endif

endmodule
